// ===== rtl/vmm_pkg.sv =====
// ----------------------------------------------------------------------------
// vmm_pkg
// shared types and constants for the video memory mirror decoder
// ----------------------------------------------------------------------------
package vmm_pkg;

  localparam int PATTERN_TABLE_BYTES = 4096;
  localparam int NAMETABLE_BYTES     = 1024;
  localparam int PATTERN_DEPTH       = 2 * PATTERN_TABLE_BYTES;
  localparam int NAMETABLE_DEPTH     = 4 * NAMETABLE_BYTES;
  localparam int PALETTE_DEPTH       = 32;

  localparam int PATTERN_AW   = $clog2(PATTERN_DEPTH);
  localparam int NAMETABLE_AW = $clog2(NAMETABLE_DEPTH);
  localparam int PALETTE_AW   = $clog2(PALETTE_DEPTH);
  localparam int NT_OFFSET_AW = $clog2(NAMETABLE_BYTES);
  localparam int INDEX_W      = PATTERN_AW;

  // access kind
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // mirroring modes
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd0;
  localparam logic [1:0] MIRROR_VERTICAL   = 2'd1;
  localparam logic [1:0] MIRROR_ONE_SCREEN = 2'd2;
  localparam logic [1:0] MIRROR_FOUR       = 2'd3;

  typedef enum logic [1:0] {
    REGION_PATTERN   = 2'd0,
    REGION_NAMETABLE = 2'd1,
    REGION_PALETTE   = 2'd2
  } region_t;

  typedef struct packed {
    region_t              region;
    logic [INDEX_W-1:0]   index;
  } vmm_access_t;

endpackage

// ===== rtl/vmm_decode.sv =====
// ----------------------------------------------------------------------------
// vmm_decode
// folds a video memory address and picks the store and entry it reaches
// ----------------------------------------------------------------------------
module vmm_decode (
  input  logic [15:0]         address,
  input  logic [1:0]          mirroring_mode,
  output vmm_pkg::vmm_access_t access
);

  logic [13:0] folded;
  logic [1:0]  logical_table;
  logic [1:0]  physical_table;

  always_comb begin
    folded = address[13:0];
    // 3000-3eff mirrors 2000-2eff
    if (folded[13:12] == 2'b11 && folded[11:8] != 4'hF) begin
      folded[12] = 1'b0;
    end
  end

  assign logical_table = folded[11:10];

  always_comb begin
    unique case (mirroring_mode)
      vmm_pkg::MIRROR_HORIZONTAL: physical_table = {1'b0, logical_table[1]};
      vmm_pkg::MIRROR_VERTICAL:   physical_table = {1'b0, logical_table[0]};
      vmm_pkg::MIRROR_ONE_SCREEN: physical_table = 2'd0;
      vmm_pkg::MIRROR_FOUR:       physical_table = logical_table;
      default:                    physical_table = logical_table;
    endcase
  end

  always_comb begin
    access.index = '0;
    if (folded[13:8] == 6'h3F) begin
      access.region = vmm_pkg::REGION_PALETTE;
      access.index[vmm_pkg::PALETTE_AW-1:0] = folded[vmm_pkg::PALETTE_AW-1:0];
    end else if (folded[13] == 1'b0) begin
      access.region = vmm_pkg::REGION_PATTERN;
      access.index = folded[vmm_pkg::PATTERN_AW-1:0];
    end else begin
      access.region = vmm_pkg::REGION_NAMETABLE;
      access.index[vmm_pkg::NAMETABLE_AW-1:0] =
        {physical_table, folded[vmm_pkg::NT_OFFSET_AW-1:0]};
    end
  end

endmodule

// ===== rtl/video_memory_mirror_decoder.sv =====
// ----------------------------------------------------------------------------
// video_memory_mirror_decoder
// byte access port onto pattern, nametable and palette memory with mirroring
// ----------------------------------------------------------------------------
// Each input transaction is one byte access: tuser[0] selects read (0) or
// write (1), tdata carries the 16-bit address and the write byte. Address
// bits 15:14 are ignored, 3000-3eff mirrors 2000-2eff, 3f00-3fff reaches the
// 32 palette bytes, below 2000 is pattern memory and 2000-2fff is mapped onto
// four nametable kilobytes by the mirroring mode (0 horizontal, 1 vertical,
// 2 one-screen, 3 four-screen). Every access returns one output transaction:
// the byte read, or zero for a write. The block takes one access per clock
// unless out_tready stalls the output; an access passes through the
// synchronous memory read register and then the output register. The stores
// have no reset: reading a byte that was never written returns an undefined
// value. Change the mirroring mode only while no access is in flight.
module video_memory_mirror_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,   // mirroring_mode
  // access input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // address[15:0], write_data[23:16]
  input  logic [0:0]  in_tuser,      // opcode[0]
  // read result
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata      // read_data[7:0]
);

  logic [1:0] mode_r;

  logic                  s1_valid_r;
  logic                  s1_op_r;
  vmm_pkg::region_t      s1_region_r;
  logic                  out_valid_r;
  logic [7:0]            out_data_r;
  logic [7:0]            out_data_nxt;

  logic                  in_accept;
  logic                  s1_adv;
  logic                  in_op;
  logic [15:0]           in_address;
  logic [7:0]            in_wdata;
  vmm_pkg::vmm_access_t  acc;

  // the three stores, each with a registered read port
  logic [7:0] pattern_mem   [vmm_pkg::PATTERN_DEPTH];
  logic [7:0] nametable_mem [vmm_pkg::NAMETABLE_DEPTH];
  logic [7:0] palette_mem   [vmm_pkg::PALETTE_DEPTH];
  logic [7:0] pattern_q;
  logic [7:0] nametable_q;
  logic [7:0] palette_q;

  assign in_op      = in_tuser[0];
  assign in_address = in_tdata[15:0];
  assign in_wdata   = in_tdata[23:16];

  // stage 1 moves on when the output register is free or being drained
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  vmm_decode u_decode (
    .address        (in_address),
    .mirroring_mode (mode_r),
    .access         (acc)
  );

  // mirroring mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= vmm_pkg::MIRROR_HORIZONTAL;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // memories: write or read only on an accepted transaction, so a stalled
  // read keeps its data on the read register
  always_ff @(posedge clk) begin
    if (in_accept && acc.region == vmm_pkg::REGION_PATTERN) begin
      if (in_op == vmm_pkg::OP_WRITE) begin
        pattern_mem[acc.index[vmm_pkg::PATTERN_AW-1:0]] <= in_wdata;
      end else begin
        pattern_q <= pattern_mem[acc.index[vmm_pkg::PATTERN_AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && acc.region == vmm_pkg::REGION_NAMETABLE) begin
      if (in_op == vmm_pkg::OP_WRITE) begin
        nametable_mem[acc.index[vmm_pkg::NAMETABLE_AW-1:0]] <= in_wdata;
      end else begin
        nametable_q <= nametable_mem[acc.index[vmm_pkg::NAMETABLE_AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && acc.region == vmm_pkg::REGION_PALETTE) begin
      if (in_op == vmm_pkg::OP_WRITE) begin
        palette_mem[acc.index[vmm_pkg::PALETTE_AW-1:0]] <= in_wdata;
      end else begin
        palette_q <= palette_mem[acc.index[vmm_pkg::PALETTE_AW-1:0]];
      end
    end
  end

  // stage 1: memory access in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r     <= in_op;
      s1_region_r <= acc.region;
    end
  end

  // pick the read port of the store that was accessed, zero for writes
  always_comb begin
    case (s1_region_r)
      vmm_pkg::REGION_PATTERN:   out_data_nxt = pattern_q;
      vmm_pkg::REGION_NAMETABLE: out_data_nxt = nametable_q;
      vmm_pkg::REGION_PALETTE:   out_data_nxt = palette_q;
      default:                   out_data_nxt = '0;
    endcase
    if (s1_op_r == vmm_pkg::OP_WRITE) begin
      out_data_nxt = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an accepted access is always in flight on the next cycle
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted access not held in stage 1");

  // a blocked stage 1 keeps its access
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_region_r) && $stable(s1_op_r)))
    else $error("stage 1 lost its access while blocked");

  // a write always returns zero
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_op_r == vmm_pkg::OP_WRITE) |=> (out_valid_r && out_data_r == 8'd0))
    else $error("write returned nonzero data");

  // a finished result and a blocked stage 1 never let a new access in
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("access accepted while pipeline is full");

endmodule

// ===== sim/video_memory_mirror_decoder_test.sv =====
// ----------------------------------------------------------------------------
// video_memory_mirror_decoder_test
// self-checking bench for the video memory mirror decoder
// ----------------------------------------------------------------------------
// Byte accesses go in through a queue-fed stream driver. A shadow copy of the
// pattern, nametable and palette stores, decoded with the current mirroring
// mode, predicts the byte of every access as it is accepted. A monitor checks
// each output transaction against the oldest prediction. A directed opener
// covers the address folds, palette bytes and ignored high bits. Random phases
// follow, each under its own mirroring mode and idling mix. Reads only target
// bytes that an earlier write has filled.
// ----------------------------------------------------------------------------
module video_memory_mirror_decoder_test;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
  } access_item_t;

  // mirroring mode for each random phase, all four modes and both extremes
  localparam logic [1:0] PHASE_MODES [8] = '{
    vmm_pkg::MIRROR_VERTICAL, vmm_pkg::MIRROR_FOUR, vmm_pkg::MIRROR_ONE_SCREEN,
    vmm_pkg::MIRROR_HORIZONTAL, vmm_pkg::MIRROR_FOUR, vmm_pkg::MIRROR_VERTICAL,
    vmm_pkg::MIRROR_HORIZONTAL, vmm_pkg::MIRROR_ONE_SCREEN
  };
  localparam int PHASE_ITEMS = 75;

  // dut ports, all inputs known from time zero
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [1:0]  cfg_wr_data = 2'd0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;    // address[15:0], write_data[23:16]
  logic [0:0]  in_tuser    = '0;    // opcode[0]
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;           // read_data[7:0]

  // stimulus and prediction
  access_item_t pending_accesses[$];
  logic [7:0]   expected_bytes[$];
  logic [15:0]  written_addrs[$];
  logic [1:0]   mirror_mode = vmm_pkg::MIRROR_HORIZONTAL;

  // shadow stores, updated as transactions are accepted
  logic [7:0] pattern_mem   [vmm_pkg::PATTERN_DEPTH];
  logic [7:0] nametable_mem [vmm_pkg::NAMETABLE_DEPTH];
  logic [7:0] palette_mem   [vmm_pkg::PALETTE_DEPTH];

  // bytes that some queued write will have filled, used to keep reads legal
  bit pattern_filled   [vmm_pkg::PATTERN_DEPTH];
  bit nametable_filled [vmm_pkg::NAMETABLE_DEPTH];
  bit palette_filled   [vmm_pkg::PALETTE_DEPTH];

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned error_count        = 0;

  video_memory_mirror_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // fold a 16-bit address onto the store and entry it reaches
  function automatic vmm_pkg::vmm_access_t decode_location(logic [15:0] addr,
                                                           logic [1:0] mode);
    vmm_pkg::vmm_access_t loc;
    logic [13:0] a;
    logic [1:0]  phys;
    a = addr[13:0];                       // bits 15:14 never matter
    if (a >= 14'h3000 && a < 14'h3F00)    // 3000-3eff mirrors 2000-2eff
      a = a - 14'h1000;
    loc.index = '0;
    if (a >= 14'h3F00) begin
      // 32 distinct palette bytes, no backdrop aliasing
      loc.region     = vmm_pkg::REGION_PALETTE;
      loc.index[4:0] = a[4:0];
    end else if (a < 14'h2000) begin
      loc.region = vmm_pkg::REGION_PATTERN;
      loc.index  = a[12:0];
    end else begin
      // logical table in bits 11:10, mapped to a physical kilobyte
      case (mode)
        vmm_pkg::MIRROR_HORIZONTAL: phys = {1'b0, a[11]};
        vmm_pkg::MIRROR_VERTICAL:   phys = {1'b0, a[10]};
        vmm_pkg::MIRROR_ONE_SCREEN: phys = 2'd0;
        default:                    phys = a[11:10];
      endcase
      loc.region      = vmm_pkg::REGION_NAMETABLE;
      loc.index[11:0] = {phys, a[9:0]};
    end
    return loc;
  endfunction

  // apply one access to the shadow stores, return the byte the dut must give
  function automatic logic [7:0] shadow_access(logic op, logic [15:0] addr,
                                               logic [7:0] wdata);
    vmm_pkg::vmm_access_t loc;
    logic [7:0]  rdata;
    loc   = decode_location(addr, mirror_mode);
    rdata = 8'h00;                        // writes answer zero
    case (loc.region)
      vmm_pkg::REGION_PATTERN:
        if (op == vmm_pkg::OP_WRITE) pattern_mem[loc.index[12:0]] = wdata;
        else rdata = pattern_mem[loc.index[12:0]];
      vmm_pkg::REGION_NAMETABLE:
        if (op == vmm_pkg::OP_WRITE) nametable_mem[loc.index[11:0]] = wdata;
        else rdata = nametable_mem[loc.index[11:0]];
      default:
        if (op == vmm_pkg::OP_WRITE) palette_mem[loc.index[4:0]] = wdata;
        else rdata = palette_mem[loc.index[4:0]];
    endcase
    return rdata;
  endfunction

  function automatic bit location_filled(vmm_pkg::vmm_access_t loc);
    case (loc.region)
      vmm_pkg::REGION_PATTERN:   return pattern_filled[loc.index[12:0]];
      vmm_pkg::REGION_NAMETABLE: return nametable_filled[loc.index[11:0]];
      default:                   return palette_filled[loc.index[4:0]];
    endcase
  endfunction

  // queue one access; writes mark the byte they fill under the current mode
  task automatic queue_access(logic op, logic [15:0] addr, logic [7:0] data);
    access_item_t item;
    vmm_pkg::vmm_access_t loc;
    item.op   = op;
    item.addr = addr;
    item.data = data;
    pending_accesses.push_back(item);
    if (op == vmm_pkg::OP_WRITE) begin
      loc = decode_location(addr, mirror_mode);
      case (loc.region)
        vmm_pkg::REGION_PATTERN:   pattern_filled[loc.index[12:0]] = 1'b1;
        vmm_pkg::REGION_NAMETABLE: nametable_filled[loc.index[11:0]] = 1'b1;
        default:                   palette_filled[loc.index[4:0]] = 1'b1;
      endcase
      written_addrs.push_back(addr);
    end
  endtask

  // about half reads of filled bytes through a random alias, the rest writes
  task automatic queue_random_access();
    logic [15:0] addr;
    vmm_pkg::vmm_access_t loc;
    bit          found;
    found = 1'b0;
    if (written_addrs.size() != 0 && $urandom_range(99) < 50) begin
      for (int tries = 0; tries < 8 && !found; tries++) begin
        addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
        addr[15:14] = 2'($urandom_range(3));
        loc = decode_location(addr, mirror_mode);
        if (loc.region == vmm_pkg::REGION_NAMETABLE) begin
          // any of the four logical tables, direct or through the 3000 mirror
          addr[13]    = 1'b1;
          addr[12]    = 1'($urandom_range(1));
          addr[11:10] = 2'($urandom_range(3));
        end else if (loc.region == vmm_pkg::REGION_PALETTE) begin
          addr[7:5] = 3'($urandom_range(7));  // 3f20-3fff folds onto the palette
        end
        found = location_filled(decode_location(addr, mirror_mode));
      end
    end
    if (found) begin
      queue_access(vmm_pkg::OP_READ, addr, 8'($urandom_range(255)));
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3: addr = 16'($urandom_range(16'h1FFF));
        4, 5, 6: begin
          addr = 16'h2000 | 16'($urandom_range(12'hFFF));
          if (addr < 16'h2F00 && $urandom_range(1)) addr = addr + 16'h1000;
        end
        7, 8: addr = 16'h3F00 | 16'($urandom_range(8'hFF));
        default: addr = 16'($urandom);    // anywhere at all
      endcase
      if ($urandom_range(1)) addr[15:14] = 2'($urandom_range(3));
      queue_access(vmm_pkg::OP_WRITE, addr, 8'($urandom_range(255)));
    end
  endtask

  // sender holds off until every queued access has come back
  task automatic wait_until_drained();
    while (pending_accesses.size() != 0 || in_tvalid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);           // margin after the last output
  endtask

  task automatic write_mirror_mode(logic [1:0] mode);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mirror_mode = mode;
  endtask

  task automatic report_failure(string what);
    error_count++;
    if (error_count <= 10) $display("%s", what);
  endtask

  // driver: predict on acceptance, then offer the next access or idle
  always @(posedge clk) begin
    access_item_t item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_bytes.push_back(shadow_access(in_tuser[0], in_tdata[15:0],
                                               in_tdata[23:16]));
      if (!in_tvalid || in_tready) begin
        if (pending_accesses.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          item = pending_accesses.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {item.data, item.addr};
          in_tuser  <= item.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, compare every output transaction
  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          report_failure($sformatf("%0t: output transaction %02h with none expected",
                                   $realtime, out_tdata));
        end else begin
          want = expected_bytes.pop_front();
          if (out_tdata !== want)
            report_failure($sformatf("%0t: read_data expected %02h, got %02h",
                                     $realtime, want, out_tdata));
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opener under the reset mode (horizontal), no idling
    queue_access(vmm_pkg::OP_WRITE, 16'h0000, 8'hFF);
    queue_access(vmm_pkg::OP_READ,  16'h0000, 8'h00);
    queue_access(vmm_pkg::OP_READ,  16'hC000, 8'hAA);   // high bits ignored
    queue_access(vmm_pkg::OP_WRITE, 16'h1FFF, 8'hA5);   // top of pattern memory
    queue_access(vmm_pkg::OP_READ,  16'h5FFF, 8'h5A);
    queue_access(vmm_pkg::OP_WRITE, 16'h2000, 8'h11);
    queue_access(vmm_pkg::OP_READ,  16'h3000, 8'h00);   // 3000 mirror
    queue_access(vmm_pkg::OP_READ,  16'h2400, 8'h00);   // horizontal pair
    queue_access(vmm_pkg::OP_WRITE, 16'h2EFF, 8'h22);
    queue_access(vmm_pkg::OP_READ,  16'h3EFF, 8'h00);   // top of the 3000 mirror
    queue_access(vmm_pkg::OP_WRITE, 16'h2FFF, 8'h33);
    queue_access(vmm_pkg::OP_READ,  16'h2BFF, 8'h00);
    queue_access(vmm_pkg::OP_WRITE, 16'h3F00, 8'h44);
    queue_access(vmm_pkg::OP_WRITE, 16'h3F10, 8'h55);   // no backdrop aliasing
    queue_access(vmm_pkg::OP_READ,  16'h3F00, 8'h00);
    queue_access(vmm_pkg::OP_READ,  16'h3F10, 8'h00);
    queue_access(vmm_pkg::OP_WRITE, 16'h3F1F, 8'h66);
    queue_access(vmm_pkg::OP_READ,  16'h3FFF, 8'h00);   // 3f20-3fff palette fold
    queue_access(vmm_pkg::OP_READ,  16'hFF20, 8'h00);
    queue_access(vmm_pkg::OP_WRITE, 16'hFFFF, 8'h77);   // all address bits high
    queue_access(vmm_pkg::OP_READ,  16'h3F1F, 8'hFF);
    queue_access(vmm_pkg::OP_READ,  16'hB000, 8'h00);   // high bits plus 3000 mirror
    queue_access(vmm_pkg::OP_WRITE, 16'h0000, 8'h00);
    queue_access(vmm_pkg::OP_READ,  16'h8000, 8'h00);
    wait_until_drained();

    // random phases, mode changed only with the pipeline empty
    for (int p = 0; p < 8; p++) begin
      write_mirror_mode(PHASE_MODES[p]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
        default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
      endcase
      repeat (PHASE_ITEMS) queue_random_access();
      wait_until_drained();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("video_memory_mirror_decoder_test OK");
    end else begin
      $display("video_memory_mirror_decoder_test NOT OK");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("video_memory_mirror_decoder_test NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/vmm_pkg.sv
rtl/vmm_decode.sv
rtl/video_memory_mirror_decoder.sv
sim/video_memory_mirror_decoder_test.sv
